// File: rtl/core/ipad_pkg.sv
// ----------------------------------------------------------------------------
// ipad_pkg
// Shared constants and types for the input protocol autodetect block.
// ----------------------------------------------------------------------------
package ipad_pkg;

	// Captures per detection window.
	localparam int WINDOW_CAPTURES = 31;
	localparam int CNT_W           = $clog2(WINDOW_CAPTURES);

	localparam int CAP_W   = 16;
	localparam int GAP_W   = 15;
	localparam int TOTAL_W = 32;
	localparam int MEAN_W  = 27;
	localparam int PRE_W   = 8;
	localparam int LEN_W   = 6;
	localparam int ARM_W   = 8;

	// The mean is the wrapping total divided by 32, which is a right shift.
	localparam int MEAN_SHIFT = 5;

	localparam logic [GAP_W-1:0]  GAP_START    = GAP_W'(20000);
	localparam logic [MEAN_W-1:0] MEAN_LIMIT   = MEAN_W'(50);
	localparam logic [GAP_W-1:0]  FAST_LOW     = GAP_W'(2);
	localparam logic [GAP_W-1:0]  FAST_HIGH    = GAP_W'(3);
	localparam logic [GAP_W-1:0]  SLOW_LOW     = GAP_W'(4);
	localparam logic [GAP_W-1:0]  SLOW_HIGH    = GAP_W'(7);
	localparam logic [GAP_W-1:0]  SERVO_FLOOR  = GAP_W'(300);

	localparam logic [PRE_W-1:0] CAP_PRESCALE_RESET = PRE_W'(10);
	localparam logic [PRE_W-1:0] PRESCALE_FAST      = PRE_W'(0);
	localparam logic [PRE_W-1:0] PRESCALE_SLOW      = PRE_W'(1);
	localparam logic [PRE_W-1:0] PRESCALE_SERVO     = PRE_W'(47);
	localparam logic [LEN_W-1:0] LEN_DSHOT          = LEN_W'(32);
	localparam logic [LEN_W-1:0] LEN_SERVO          = LEN_W'(2);
	localparam logic [ARM_W-1:0] ARM_SERVO          = ARM_W'(35);
	localparam logic [ARM_W-1:0] ARM_RESET          = ARM_W'(0);

	// Statistics of one finished window.
	typedef struct packed {
		logic [GAP_W-1:0]  least;
		logic [MEAN_W-1:0] mean;
	} win_sum_t;

	// One result word, declared from the highest field down so that
	// dshot_detected lands in bit 0.
	typedef struct packed {
		logic [MEAN_W-1:0] mean_gap;
		logic [GAP_W-1:0]  smallest_gap;
		logic              preset_counter;
		logic [ARM_W-1:0]  arming_count;
		logic [LEN_W-1:0]  capture_length;
		logic [PRE_W-1:0]  output_prescale;
		logic [PRE_W-1:0]  capture_prescale;
		logic              detection_done;
		logic              servo_detected;
		logic              dshot_detected;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: rtl/core/ipad_gap_acc.sv
// ----------------------------------------------------------------------------
// ipad_gap_acc
// Per-window gap statistics: previous capture, position, least gap and total.
// ----------------------------------------------------------------------------
module ipad_gap_acc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [ipad_pkg::CAP_W-1:0]         cap,
	output logic                               last,
	output ipad_pkg::win_sum_t                 sum
);

	logic [ipad_pkg::CAP_W-1:0]   prev_q;
	logic [ipad_pkg::CNT_W-1:0]   count_q;
	logic [ipad_pkg::GAP_W-1:0]   least_q;
	logic [ipad_pkg::TOTAL_W-1:0] total_q;

	logic [ipad_pkg::CAP_W:0]     diff17;
	logic [ipad_pkg::TOTAL_W-1:0] diff32;
	logic                         first;
	logic                         take_min;
	logic [ipad_pkg::GAP_W-1:0]   least_nxt;
	logic [ipad_pkg::TOTAL_W-1:0] total_nxt;

	// A capture below the previous one borrows; sign extension gives the
	// 32-bit wrapped difference, which is too large to become the minimum.
	assign diff17 = {1'b0, cap} - {1'b0, prev_q};
	assign diff32 = {{(ipad_pkg::TOTAL_W-ipad_pkg::CAP_W-1){diff17[ipad_pkg::CAP_W]}}, diff17};
	assign first  = (count_q == '0);
	assign last   = (count_q == ipad_pkg::CNT_W'(ipad_pkg::WINDOW_CAPTURES - 1));

	assign take_min = !first && !diff17[ipad_pkg::CAP_W]
		&& (diff17[ipad_pkg::CAP_W-1:0] != '0)
		&& (diff17[ipad_pkg::CAP_W-1:0] < {1'b0, least_q});

	assign least_nxt = take_min ? diff17[ipad_pkg::GAP_W-1:0] : least_q;
	assign total_nxt = first ? total_q : total_q + diff32;

	assign sum.least = least_nxt;
	assign sum.mean  = total_nxt[ipad_pkg::TOTAL_W-1:ipad_pkg::MEAN_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			count_q <= '0;
			least_q <= ipad_pkg::GAP_START;
			total_q <= '0;
		end else if (step) begin
			prev_q <= cap;
			if (last) begin
				count_q <= '0;
				least_q <= ipad_pkg::GAP_START;
				total_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				least_q <= least_nxt;
				total_q <= total_nxt;
			end
		end
	end

endmodule

// File: rtl/core/ipad_classify.sv
// ----------------------------------------------------------------------------
// ipad_classify
// Sticky protocol mode and timer settings, updated at the end of each window.
// ----------------------------------------------------------------------------
module ipad_classify (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  ipad_pkg::win_sum_t sum,
	output ipad_pkg::result_t  res
);

	logic                        dshot_q;
	logic                        servo_q;
	logic                        known_q;
	logic [ipad_pkg::PRE_W-1:0]  cpre_q;
	logic [ipad_pkg::PRE_W-1:0]  opre_q;
	logic [ipad_pkg::LEN_W-1:0]  len_q;
	logic [ipad_pkg::ARM_W-1:0]  arm_q;

	logic dshot_en;
	logic servo_en;
	logic mean_ok;
	logic hit_fast;
	logic hit_slow;
	logic hit_servo;

	// Once a mode is set only its own rule is rechecked.
	assign dshot_en = dshot_q || !servo_q;
	assign servo_en = servo_q || !dshot_q;
	assign mean_ok  = sum.mean < ipad_pkg::MEAN_LIMIT;

	assign hit_fast = dshot_en && mean_ok
		&& (sum.least >= ipad_pkg::FAST_LOW) && (sum.least <= ipad_pkg::FAST_HIGH);
	assign hit_slow = dshot_en && mean_ok
		&& (sum.least >= ipad_pkg::SLOW_LOW) && (sum.least <= ipad_pkg::SLOW_HIGH);
	assign hit_servo = servo_en
		&& (sum.least > ipad_pkg::SERVO_FLOOR) && (sum.least < ipad_pkg::GAP_START);

	always_comb begin
		res.dshot_detected   = dshot_q || hit_fast || hit_slow;
		res.servo_detected   = servo_q || hit_servo;
		res.detection_done   = known_q || hit_fast || hit_slow || hit_servo;
		res.capture_prescale = cpre_q;
		res.output_prescale  = opre_q;
		res.capture_length   = len_q;
		res.arming_count     = arm_q;
		if (hit_fast) begin
			res.capture_prescale = ipad_pkg::PRESCALE_FAST;
			res.output_prescale  = ipad_pkg::PRESCALE_FAST;
			res.capture_length   = ipad_pkg::LEN_DSHOT;
		end
		if (hit_slow) begin
			res.capture_prescale = ipad_pkg::PRESCALE_SLOW;
			res.output_prescale  = ipad_pkg::PRESCALE_SLOW;
			res.capture_length   = ipad_pkg::LEN_DSHOT;
		end
		if (hit_servo) begin
			res.capture_prescale = ipad_pkg::PRESCALE_SERVO;
			res.capture_length   = ipad_pkg::LEN_SERVO;
			res.arming_count     = ipad_pkg::ARM_SERVO;
		end
		res.preset_counter = hit_slow;
		res.smallest_gap   = sum.least;
		res.mean_gap       = sum.mean;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dshot_q <= 1'b0;
			servo_q <= 1'b0;
			known_q <= 1'b0;
			cpre_q  <= ipad_pkg::CAP_PRESCALE_RESET;
			opre_q  <= ipad_pkg::PRESCALE_FAST;
			len_q   <= ipad_pkg::LEN_DSHOT;
			arm_q   <= ipad_pkg::ARM_RESET;
		end else if (fire) begin
			dshot_q <= res.dshot_detected;
			servo_q <= res.servo_detected;
			known_q <= res.detection_done;
			cpre_q  <= res.capture_prescale;
			opre_q  <= res.output_prescale;
			len_q   <= res.capture_length;
			arm_q   <= res.arming_count;
		end
	end

endmodule

// File: rtl/core/input_protocol_autodetect.sv
// ----------------------------------------------------------------------------
// input_protocol_autodetect
// Classifies the input signal as DShot or servo PWM from windows of edge
// capture timestamps and reports the resulting timer settings.
// ----------------------------------------------------------------------------
//  channel   direction  word                          rule
//  s_*       in         capture_time                  one word per edge capture
//  m_*       out        mode, timer settings, stats   one word per finished window
//
//  An accepted capture sits in the input register, and the gap subtract,
//  minimum compare and 32-bit add finish in that same cycle; a new capture is
//  taken every cycle unless a stalled result holds back a window's last one,
//  which also runs the classification and loads the result register.
//  Reset clears all window statistics and the detected mode.
//  A stalled result only holds back the last capture of the next window.
module input_protocol_autodetect (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ipad_pkg::CAP_W-1:0]    s_tdata,  // [15:0] capture_time
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] dshot_detected, [1] servo_detected, [2] detection_done,
	// [10:3] capture_prescale, [18:11] output_prescale, [24:19] capture_length,
	// [32:25] arming_count, [33] preset_counter, [48:34] smallest_gap,
	// [75:49] mean_gap, [79:76] zero
	output logic [ipad_pkg::OUT_W-1:0]    m_tdata
);

	logic                       valid_s1;
	logic [ipad_pkg::CAP_W-1:0] cap_s1;
	logic                       last;
	logic                       out_free;
	logic                       go_s1;
	logic                       fire;
	ipad_pkg::win_sum_t         sum;
	ipad_pkg::result_t          res;
	ipad_pkg::result_t          res_s2;

	assign out_free = !m_tvalid || m_tready;
	assign go_s1    = valid_s1 && (!last || out_free);
	assign fire     = go_s1 && last;
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cap_s1 <= s_tdata;
		end
	end

	ipad_gap_acc u_gap_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go_s1),
		.cap    (cap_s1),
		.last   (last),
		.sum    (sum)
	);

	ipad_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.sum    (sum),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {{(ipad_pkg::OUT_W-ipad_pkg::RESULT_W){1'b0}}, res_s2};

	// A window that completes must always present its result next cycle.
	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("finished window did not produce a result");

	// The sticky done flag matches the two mode flags.
	a_done_modes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.detection_done == (res_s2.dshot_detected || res_s2.servo_detected)))
		else $error("detection_done disagrees with mode flags");

	// The two modes exclude each other.
	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_s2.dshot_detected && res_s2.servo_detected))
		else $error("both modes detected");

	// A counter preset only comes with slow DShot settings.
	a_preset: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.preset_counter) |->
		(res_s2.dshot_detected && res_s2.capture_prescale == ipad_pkg::PRESCALE_SLOW))
		else $error("preset without slow DShot settings");

	// The minimum never exceeds its starting value.
	a_least: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.smallest_gap <= ipad_pkg::GAP_START))
		else $error("smallest gap above start value");

endmodule

// File: tb/input_protocol_autodetect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_protocol_autodetect_tb
// Streams capture timestamps into the detector in windows that imitate fast
// and slow DShot, servo PWM and assorted noise. A cycle-free predictor tracks
// the running gap statistics and the detected mode, and every result word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module input_protocol_autodetect_tb;

	localparam int WIN_LEN      = ipad_pkg::WINDOW_CAPTURES;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 20;

	// Detection thresholds, as the protocol defines them.
	localparam int unsigned GAP_INIT    = 20000;
	localparam int unsigned MEAN_CEIL   = 50;
	localparam int unsigned SERVO_MIN   = 301;
	localparam int unsigned SERVO_MAX   = 19999;
	localparam logic [7:0]  CAP_PRE_RST = 8'd10;
	localparam logic [7:0]  CAP_PRE_SRV = 8'd47;
	localparam logic [7:0]  ARM_SRV     = 8'd35;
	localparam logic [5:0]  LEN_FULL    = 6'd32;
	localparam logic [5:0]  LEN_SRV     = 6'd2;

	typedef enum int {
		WK_FAST,   // fast DShot gaps
		WK_SLOW,   // slow DShot gaps
		WK_SERVO,  // servo pulse period gaps
		WK_NOISE,  // unrelated captures
		WK_EDGE,   // one chosen smallest gap near a rule boundary
		WK_MEAN,   // DShot-like gaps with the mean close to its limit
		WK_FLAT,   // all captures equal
		WK_WRAP    // captures jumping between the counter extremes
	} window_kind_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ipad_pkg::CAP_W-1:0]     s_tdata;   // [15:0] capture_time
	logic                           m_tvalid;
	logic                           m_tready;
	// [0] dshot_detected, [1] servo_detected, [2] detection_done,
	// [10:3] capture_prescale, [18:11] output_prescale, [24:19] capture_length,
	// [32:25] arming_count, [33] preset_counter, [48:34] smallest_gap,
	// [75:49] mean_gap, [79:76] zero
	logic [ipad_pkg::OUT_W-1:0]     m_tdata;

	// Predicted detector state.
	logic [15:0]  prev_cap;
	int unsigned  win_pos;
	logic [14:0]  run_min;
	logic [31:0]  run_sum;
	logic         dshot_on;
	logic         servo_on;
	logic         locked;
	logic [7:0]   cap_pre;
	logic [7:0]   out_pre;
	logic [5:0]   cap_len;
	logic [7:0]   arm_cnt;

	ipad_pkg::result_t due_reports[$];
	int unsigned  mismatch_count = 0;
	int unsigned  quiet_cycles = 0;
	bit           tx_idle_en = 1'b1;
	bit           rx_idle_en = 1'b1;
	bit           hold_asked = 1'b0;
	bit           dshot_first;

	input_protocol_autodetect dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic clear_tracker;
		prev_cap = '0;
		win_pos  = 0;
		run_min  = 15'(GAP_INIT);
		run_sum  = '0;
		dshot_on = 1'b0;
		servo_on = 1'b0;
		locked   = 1'b0;
		cap_pre  = CAP_PRE_RST;
		out_pre  = 8'd0;
		cap_len  = LEN_FULL;
		arm_cnt  = 8'd0;
	endtask

	// Returns 1 when the slow rule fired, which asks for the counter preset.
	function automatic bit apply_dshot(logic [14:0] g, logic [31:0] mean);
		bit slow_hit;
		slow_hit = 1'b0;
		if (g >= 2 && g <= 3 && mean < MEAN_CEIL) begin
			dshot_on = 1'b1;
			cap_pre  = 8'd0;
			out_pre  = 8'd0;
			cap_len  = LEN_FULL;
			locked   = 1'b1;
		end
		if (g >= 4 && g <= 7 && mean < MEAN_CEIL) begin
			dshot_on = 1'b1;
			cap_pre  = 8'd1;
			out_pre  = 8'd1;
			cap_len  = LEN_FULL;
			locked   = 1'b1;
			slow_hit = 1'b1;
		end
		return slow_hit;
	endfunction

	function automatic void apply_servo(logic [14:0] g);
		if (g >= SERVO_MIN && g <= SERVO_MAX) begin
			servo_on = 1'b1;
			cap_pre  = CAP_PRE_SRV;
			arm_cnt  = ARM_SRV;
			cap_len  = LEN_SRV;
			locked   = 1'b1;
		end
	endfunction

	// Folds one accepted capture into the window and queues the report that
	// the last capture of a window produces.
	task automatic advance_window(input logic [15:0] cap);
		logic [31:0] diff;
		logic [31:0] mean;
		logic [14:0] g;
		logic        had_dshot;
		logic        had_servo;
		bit          slow_hit;
		ipad_pkg::result_t r;
		if (win_pos != 0) begin
			diff = 32'(cap) - 32'(prev_cap);
			if (diff != 0 && diff < 32'(run_min))
				run_min = diff[14:0];
			run_sum += diff;
		end
		prev_cap = cap;
		if (win_pos + 1 < WIN_LEN) begin
			win_pos++;
			return;
		end
		g = run_min;
		mean = run_sum >> 5;
		had_dshot = dshot_on;
		had_servo = servo_on;
		slow_hit = 1'b0;
		// With no mode known yet both rule sets are tried.
		if (had_dshot || !had_servo)
			slow_hit = apply_dshot(g, mean);
		if (had_servo || !had_dshot)
			apply_servo(g);
		r = '0;
		r.dshot_detected   = dshot_on;
		r.servo_detected   = servo_on;
		r.detection_done   = locked;
		r.capture_prescale = cap_pre;
		r.output_prescale  = out_pre;
		r.capture_length   = cap_len;
		r.arming_count     = arm_cnt;
		r.preset_counter   = slow_hit;
		r.smallest_gap     = g;
		r.mean_gap         = mean[ipad_pkg::MEAN_W-1:0];
		due_reports.push_back(r);
		win_pos = 0;
		run_min = 15'(GAP_INIT);
		run_sum = '0;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_capture(input logic [15:0] cap);
		int unsigned pause;
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			pause = $urandom_range(1, 19);
			s_tvalid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
		s_tdata  <= cap;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_window(cap);
		@(negedge clk);
	endtask

	task automatic send_window(input window_kind_t kind, input int arg = -1);
		logic [15:0] caps [WIN_LEN];
		logic [15:0] step;
		int unsigned pick;
		int unsigned target;
		int unsigned spread;
		int unsigned rest;
		case (kind)
			WK_FAST, WK_SLOW: begin
				caps[0] = 16'($urandom_range(0, 64000));
				for (int i = 1; i < WIN_LEN; i++) begin
					if ($urandom_range(0, 7) == 0)
						step = '0;
					else if (kind == WK_FAST)
						step = 16'($urandom_range(2, 3));
					else if ($urandom_range(0, 3) == 0)
						step = 16'($urandom_range(8, 40));
					else
						step = 16'($urandom_range(4, 7));
					caps[i] = caps[i-1] + step;
				end
			end
			WK_SERVO: begin
				caps[0] = 16'($urandom_range(0, 65535));
				for (int i = 1; i < WIN_LEN; i++)
					caps[i] = caps[i-1] + 16'($urandom_range(SERVO_MIN, SERVO_MAX));
			end
			WK_NOISE: begin
				for (int i = 0; i < WIN_LEN; i++)
					caps[i] = 16'($urandom_range(0, 65535));
			end
			WK_EDGE: begin
				if (arg >= 0) begin
					pick = arg;
				end else begin
					case ($urandom_range(0, 10))
						0: pick = 1;
						1: pick = 2;
						2: pick = 3;
						3: pick = 4;
						4: pick = 7;
						5: pick = 8;
						6: pick = 300;
						7: pick = 301;
						8: pick = 19999;
						9: pick = 20000;
						default: pick = 20001;
					endcase
				end
				// The chosen gap sits first so that it never wraps the counter.
				caps[0] = 16'($urandom_range(0, 65535 - pick));
				caps[1] = caps[0] + 16'(pick);
				for (int i = 2; i < WIN_LEN; i++) begin
					if ($urandom_range(0, 7) == 0)
						step = '0;
					else
						step = 16'(pick + $urandom_range(0, 40));
					caps[i] = caps[i-1] + step;
				end
			end
			WK_MEAN: begin
				pick = $urandom_range(2, 7);
				target = (arg >= 0) ? arg : $urandom_range(1560, 1660);
				spread = (target - pick) / (WIN_LEN - 2);
				rest = (target - pick) - spread * (WIN_LEN - 2);
				caps[0] = 16'($urandom_range(0, 63000));
				caps[1] = caps[0] + 16'(pick);
				for (int i = 2; i < WIN_LEN; i++)
					caps[i] = caps[i-1] + 16'(spread + ((i == WIN_LEN - 1) ? rest : 0));
			end
			WK_FLAT: begin
				caps[0] = 16'($urandom_range(0, 65535));
				for (int i = 1; i < WIN_LEN; i++)
					caps[i] = caps[0];
			end
			default: begin
				// Backward jumps give huge differences that overflow the sum.
				for (int i = 0; i < WIN_LEN; i++) begin
					if (arg >= 0)
						caps[i] = (i % 2 == 0) ? 16'hffff : 16'h0000;
					else if (i % 2 == 0)
						caps[i] = 16'($urandom_range(16'hf000, 16'hffff));
					else
						caps[i] = 16'($urandom_range(0, 16'h0fff));
				end
			end
		endcase
		for (int i = 0; i < WIN_LEN; i++)
			send_capture(caps[i]);
	endtask

	function automatic window_kind_t pick_kind;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return WK_FAST;
		if (r < 40)
			return WK_SLOW;
		if (r < 60)
			return WK_SERVO;
		if (r < 72)
			return WK_EDGE;
		if (r < 82)
			return WK_MEAN;
		if (r < 90)
			return WK_NOISE;
		if (r < 95)
			return WK_FLAT;
		return WK_WRAP;
	endfunction

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Windows that match no rule leave the detector undecided.
	task automatic test_no_mode;
		send_window(WK_FLAT);
		send_window(WK_WRAP, 0);
		send_window(WK_EDGE, 1);
		send_window(WK_EDGE, 8);
		send_window(WK_EDGE, 300);
		send_window(WK_EDGE, 20000);
		send_window(WK_MEAN, 1600);
	endtask

	// Only one mode can ever be locked after the single reset, so the seed
	// decides which one this run follows.
	task automatic test_first_lock;
		dshot_first = $urandom_range(0, 1);
		if (dshot_first)
			send_window(WK_EDGE, 3);
		else
			send_window(WK_EDGE, 301);
	endtask

	task automatic test_locked_rechecks;
		if (dshot_first) begin
			send_window(WK_SLOW);
			send_window(WK_EDGE, 7);
			send_window(WK_EDGE, 2);
			send_window(WK_MEAN, 1599);
			send_window(WK_EDGE, 4);
			send_window(WK_EDGE, 8);
			send_window(WK_SERVO);
		end else begin
			send_window(WK_EDGE, 19999);
			send_window(WK_SERVO);
			send_window(WK_FAST);
			send_window(WK_SLOW);
			send_window(WK_EDGE, 20000);
		end
	endtask

	task automatic test_random_windows(input int unsigned count);
		for (int unsigned n = 0; n < count; n++)
			send_window(pick_kind());
	endtask

	// The receiver holds off while captures keep coming, so the finished
	// window backs up into the input; then the sender waits for every report.
	task automatic test_backpressure;
		tx_idle_en = 1'b0;
		hold_asked = 1'b1;
		for (int n = 0; n < 4; n++)
			send_window(pick_kind());
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_quiet_finish;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_windows(10);
	endtask

	initial begin : rx_side
		int unsigned n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked) begin
				hold_asked = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 19);
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		ipad_pkg::result_t want;
		ipad_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = ipad_pkg::result_t'(m_tdata[ipad_pkg::RESULT_W-1:0]);
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h",
					$time, m_tdata);
				mismatch_count++;
			end else begin
				want = due_reports.pop_front();
				check_field("dshot_detected", want.dshot_detected, got.dshot_detected);
				check_field("servo_detected", want.servo_detected, got.servo_detected);
				check_field("detection_done", want.detection_done, got.detection_done);
				check_field("capture_prescale", want.capture_prescale,
					got.capture_prescale);
				check_field("output_prescale", want.output_prescale, got.output_prescale);
				check_field("capture_length", want.capture_length, got.capture_length);
				check_field("arming_count", want.arming_count, got.arming_count);
				check_field("preset_counter", want.preset_counter, got.preset_counter);
				check_field("smallest_gap", want.smallest_gap, got.smallest_gap);
				check_field("mean_gap", want.mean_gap, got.mean_gap);
				check_field("padding", '0,
					32'(m_tdata[ipad_pkg::OUT_W-1:ipad_pkg::RESULT_W]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		clear_tracker();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_no_mode();
		test_first_lock();
		test_locked_rechecks();
		test_random_windows(29);
		test_backpressure();
		test_quiet_finish();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
